/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL files; rmtc_scan uses them.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/rmtc_pkg.sv */
package rmtc_pkg;

	localparam int unsigned POS_W = 24;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [7:0] OP_STORE = 8'h32;

	localparam logic [15:0] ADDR_A0 = 16'h4000;
	localparam logic [15:0] ADDR_A1 = 16'h8000;
	localparam logic [15:0] ADDR_A2 = 16'hA000;
	localparam logic [15:0] ADDR_S0 = 16'h5000;
	localparam logic [15:0] ADDR_S1 = 16'h9000;
	localparam logic [15:0] ADDR_S2 = 16'hB000;
	localparam logic [15:0] ADDR_B8_LO = 16'h6800;
	localparam logic [15:0] ADDR_B8_HI = 16'h7800;
	localparam logic [15:0] ADDR_B16 = 16'h77FF;
	localparam logic [15:0] ADDR_SHARED_A = 16'h6000;
	localparam logic [15:0] ADDR_SHARED_S = 16'h7000;

	localparam logic [POS_W-1:0] POS_AB0 = 24'h000001;
	localparam logic [POS_W-1:0] POS_AB4 = 24'h004001;
	localparam logic [POS_W-1:0] POS_SIG_END = 24'd24;
	localparam logic [POS_W-1:0] POS_TEXT_END = 24'h028008;
	localparam logic [POS_W-4:0] SIG_ROW = 21'h000002;
	localparam logic [POS_W-4:0] TEXT_ROW = 21'h005000;

	localparam logic [POS_W-1:0] SIZE_MIN = 24'd8192;
	localparam logic [POS_W-1:0] SIZE_MAX = 24'd15728640;
	localparam logic [POS_W-1:0] SIZE_16K = 24'd16384;
	localparam logic [POS_W-1:0] SIZE_32K = 24'd32768;
	localparam logic [POS_W-1:0] SIZE_48K = 24'd49152;
	localparam logic [POS_W-1:0] SIZE_64K = 24'd65536;
	localparam logic [POS_W-1:0] SIZE_512K = 24'd524288;
	localparam logic [POS_W-1:0] SIZE_RESET = 24'd16384;

	typedef enum logic [3:0] {
		MT_UNKNOWN   = 4'd0,
		MT_PLAIN16   = 4'd1,
		MT_PLAIN32   = 4'd2,
		MT_A_SND     = 4'd3,
		MT_PLANAR48  = 4'd4,
		MT_B8        = 4'd5,
		MT_B16       = 4'd6,
		MT_A         = 4'd7,
		MT_NEO8      = 4'd8,
		MT_NEO16     = 4'd9,
		MT_B16X      = 4'd12,
		MT_PLANAR64  = 4'd13,
		MT_TEXT512   = 4'd14
	} mapper_t;

	typedef struct packed {
		logic ab0;
		logic ab4;
		logic sig_x;
		logic sig_n8;
		logic sig_n16;
		logic text;
	} hdr_flags_t;

	localparam hdr_flags_t HDR_CLEAR = '{ab0: 1'b0, ab4: 1'b0, sig_x: 1'b1,
		sig_n8: 1'b1, sig_n16: 1'b1, text: 1'b1};

	typedef struct packed {
		hdr_flags_t hdr;
		logic sigs_seen;
		logic text_seen;
	} snap_flags_t;

	function automatic logic [7:0] sig_x_byte(input logic [2:0] k);
		logic [7:0] v;
		unique case (k)
			3'd0: v = 8'h41;
			3'd1: v = 8'h53;
			3'd2: v = 8'h43;
			3'd3: v = 8'h49;
			3'd4: v = 8'h49;
			3'd5: v = 8'h31;
			3'd6: v = 8'h36;
			default: v = 8'h58;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] sig_n8_byte(input logic [2:0] k);
		logic [7:0] v;
		unique case (k)
			3'd0: v = 8'h52;
			3'd1: v = 8'h4F;
			3'd2: v = 8'h4D;
			3'd3: v = 8'h5F;
			3'd4: v = 8'h4E;
			3'd5: v = 8'h45;
			3'd6: v = 8'h4F;
			default: v = 8'h38;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] sig_n16_byte(input logic [2:0] k);
		logic [7:0] v;
		unique case (k)
			3'd0: v = 8'h52;
			3'd1: v = 8'h4F;
			3'd2: v = 8'h4D;
			3'd3: v = 8'h5F;
			3'd4: v = 8'h4E;
			3'd5: v = 8'h45;
			3'd6: v = 8'h31;
			default: v = 8'h36;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] text_mark_byte(input logic [2:0] k);
		logic [7:0] v;
		unique case (k)
			3'd0: v = 8'h4D;
			3'd1: v = 8'h61;
			3'd2: v = 8'h6E;
			3'd3: v = 8'h62;
			3'd4: v = 8'h6F;
			3'd5: v = 8'h77;
			3'd6: v = 8'h20;
			default: v = 8'h32;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/rmtc_scan.sv */
`include "assert_macros.svh"

module rmtc_scan import rmtc_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [POS_W-1:0]       image_size,
	input  logic                   step,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	input  logic                   snap_take,
	output logic                   snap_valid,
	output logic [COUNT_WIDTH-1:0] snap_cnt_a,
	output logic [COUNT_WIDTH-1:0] snap_cnt_s,
	output logic [COUNT_WIDTH-1:0] snap_cnt_b8,
	output logic [COUNT_WIDTH-1:0] snap_cnt_b16,
	output logic [COUNT_WIDTH-1:0] snap_raw0,
	output logic [COUNT_WIDTH-1:0] snap_raw1,
	output logic [COUNT_WIDTH-1:0] snap_raw2,
	output snap_flags_t            snap_flags
);

	logic [POS_W-1:0]       pos_q, pos_nx;
	logic [7:0]             prev0_q, prev1_q;
	logic [COUNT_WIDTH-1:0] cnt_a_q, cnt_s_q, cnt_b8_q, cnt_b16_q;
	logic [COUNT_WIDTH-1:0] raw0_q, raw1_q, raw2_q;
	logic [COUNT_WIDTH-1:0] cnt_a_nx, cnt_s_nx, cnt_b8_nx, cnt_b16_nx;
	logic [COUNT_WIDTH-1:0] raw0_nx, raw1_nx, raw2_nx;
	hdr_flags_t             hdr_q, hdr_nx;
	logic                   snap_valid_q;
	logic                   in_img, store_ok;
	logic [15:0]            word;
	logic                   bump_a, bump_s, bump_b8, bump_b16;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c,
		input logic en);
		return (en && c != '1) ? c + 1'b1 : c;
	endfunction

	assign word = {in_byte, prev0_q};
	assign in_img = pos_q < image_size;
	// The store opcode two bytes back counts only when its operand ends before the last byte of the image.
	assign store_ok = in_img && pos_q >= 24'd2 && prev1_q == OP_STORE
		&& ({1'b0, pos_q} + 25'd1) < {1'b0, image_size};
	assign pos_nx = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

	always_comb begin
		bump_a = 1'b0;
		bump_s = 1'b0;
		bump_b8 = 1'b0;
		bump_b16 = 1'b0;
		if (store_ok) begin
			unique case (word)
				ADDR_A0, ADDR_A1, ADDR_A2: bump_a = 1'b1;
				ADDR_S0, ADDR_S1, ADDR_S2: bump_s = 1'b1;
				ADDR_B8_LO, ADDR_B8_HI: bump_b8 = 1'b1;
				ADDR_B16: bump_b16 = 1'b1;
				ADDR_SHARED_A: begin
					bump_a = 1'b1;
					bump_b8 = 1'b1;
					bump_b16 = 1'b1;
				end
				ADDR_SHARED_S: begin
					bump_s = 1'b1;
					bump_b8 = 1'b1;
					bump_b16 = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		hdr_nx = hdr_q;
		if (in_img) begin
			if (pos_q == POS_AB0 && prev0_q == 8'h41 && in_byte == 8'h42) begin
				hdr_nx.ab0 = 1'b1;
			end
			if (pos_q == POS_AB4 && prev0_q == 8'h41 && in_byte == 8'h42) begin
				hdr_nx.ab4 = 1'b1;
			end
			if (pos_q[POS_W-1:3] == SIG_ROW) begin
				if (in_byte != sig_x_byte(pos_q[2:0])) begin
					hdr_nx.sig_x = 1'b0;
				end
				if (in_byte != sig_n8_byte(pos_q[2:0])) begin
					hdr_nx.sig_n8 = 1'b0;
				end
				if (in_byte != sig_n16_byte(pos_q[2:0])) begin
					hdr_nx.sig_n16 = 1'b0;
				end
			end
			if (pos_q[POS_W-1:3] == TEXT_ROW && in_byte != text_mark_byte(pos_q[2:0])) begin
				hdr_nx.text = 1'b0;
			end
		end
	end

	// Raw constants are checked in priority order, so at most one bumps per byte.
	always_comb begin
		raw0_nx = raw0_q;
		raw1_nx = raw1_q;
		raw2_nx = raw2_q;
		if (in_img && pos_q != '0) begin
			if (word == ADDR_B16) begin
				raw0_nx = sat_inc(raw0_q, 1'b1);
			end else if (word == ADDR_B8_LO) begin
				raw1_nx = sat_inc(raw1_q, 1'b1);
			end else if (word == ADDR_B8_HI) begin
				raw2_nx = sat_inc(raw2_q, 1'b1);
			end
		end
	end

	assign cnt_a_nx = sat_inc(cnt_a_q, bump_a);
	assign cnt_s_nx = sat_inc(cnt_s_q, bump_s);
	assign cnt_b8_nx = sat_inc(cnt_b8_q, bump_b8);
	assign cnt_b16_nx = sat_inc(cnt_b16_q, bump_b16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			prev0_q <= '0;
			prev1_q <= '0;
			cnt_a_q <= '0;
			cnt_s_q <= '0;
			cnt_b8_q <= '0;
			cnt_b16_q <= '0;
			raw0_q <= '0;
			raw1_q <= '0;
			raw2_q <= '0;
			hdr_q <= HDR_CLEAR;
			snap_valid_q <= 1'b0;
		end else begin
			if (step && in_last) begin
				pos_q <= '0;
				prev0_q <= '0;
				prev1_q <= '0;
				cnt_a_q <= '0;
				cnt_s_q <= '0;
				cnt_b8_q <= '0;
				cnt_b16_q <= '0;
				raw0_q <= '0;
				raw1_q <= '0;
				raw2_q <= '0;
				hdr_q <= HDR_CLEAR;
			end else if (step) begin
				pos_q <= pos_nx;
				if (in_img) begin
					prev0_q <= in_byte;
					prev1_q <= prev0_q;
				end
				cnt_a_q <= cnt_a_nx;
				cnt_s_q <= cnt_s_nx;
				cnt_b8_q <= cnt_b8_nx;
				cnt_b16_q <= cnt_b16_nx;
				raw0_q <= raw0_nx;
				raw1_q <= raw1_nx;
				raw2_q <= raw2_nx;
				hdr_q <= hdr_nx;
			end
			if (step && in_last) begin
				snap_valid_q <= 1'b1;
			end else if (snap_take) begin
				snap_valid_q <= 1'b0;
			end
		end
	end

	// Snapshot of the final state of one image, held for the decision stage.
	always_ff @(posedge clk) begin
		if (step && in_last) begin
			snap_cnt_a <= cnt_a_nx;
			snap_cnt_s <= cnt_s_nx;
			snap_cnt_b8 <= cnt_b8_nx;
			snap_cnt_b16 <= cnt_b16_nx;
			snap_raw0 <= raw0_nx;
			snap_raw1 <= raw1_nx;
			snap_raw2 <= raw2_nx;
			snap_flags.hdr <= hdr_nx;
			snap_flags.sigs_seen <= pos_nx >= POS_SIG_END && image_size >= POS_SIG_END;
			snap_flags.text_seen <= pos_nx >= POS_TEXT_END && image_size >= POS_TEXT_END;
		end
	end

	assign snap_valid = snap_valid_q;

	`ASSERT_NEXT(a_last_fills_snap, step && in_last, snap_valid)
	`ASSERT_NEXT(a_last_clears_pos, step && in_last, pos_q == '0 && cnt_a_q == '0)
	`ASSERT_NEXT(a_snap_holds, snap_valid && !snap_take && !(step && in_last), snap_valid)
	`ASSERT_IMPL(a_no_overrun, step && in_last, !snap_valid || snap_take)

endmodule

/* rtl/core/rmtc_decide.sv */
module rmtc_decide import rmtc_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [POS_W-1:0]       image_size,
	input  logic                   snap_valid,
	input  logic [COUNT_WIDTH-1:0] snap_cnt_a,
	input  logic [COUNT_WIDTH-1:0] snap_cnt_s,
	input  logic [COUNT_WIDTH-1:0] snap_cnt_b8,
	input  logic [COUNT_WIDTH-1:0] snap_cnt_b16,
	input  logic [COUNT_WIDTH-1:0] snap_raw0,
	input  logic [COUNT_WIDTH-1:0] snap_raw1,
	input  logic [COUNT_WIDTH-1:0] snap_raw2,
	input  snap_flags_t            snap_flags,
	output logic                   snap_take,
	input  logic                   res_ready,
	output logic                   res_valid,
	output mapper_t                res_type
);

	logic                   res_valid_q;
	mapper_t                res_type_q, kind;
	logic [COUNT_WIDTH-1:0] sc_b8;
	logic [COUNT_WIDTH-1:0] best1, best2, best3;
	mapper_t                vote1, vote2, vote3, vote4;
	logic                   b16_wins_raw;
	hdr_flags_t             h;

	assign h = snap_flags.hdr;
	assign sc_b8 = (snap_cnt_b8 != '0) ? snap_cnt_b8 - 1'b1 : '0;
	assign b16_wins_raw = {1'b0, snap_raw0} > ({1'b0, snap_raw1} + {1'b0, snap_raw2});

	// Vote over the four scores; a later nonzero score wins ties.
	always_comb begin
		best1 = snap_cnt_s;
		vote1 = (snap_cnt_s != '0) ? MT_A_SND : MT_UNKNOWN;
		best2 = best1;
		vote2 = vote1;
		if (snap_cnt_a != '0 && snap_cnt_a >= best1) begin
			best2 = snap_cnt_a;
			vote2 = MT_A;
		end
		best3 = best2;
		vote3 = vote2;
		if (sc_b8 != '0 && sc_b8 >= best2) begin
			best3 = sc_b8;
			vote3 = MT_B8;
		end
		vote4 = vote3;
		if (snap_cnt_b16 != '0 && snap_cnt_b16 >= best3) begin
			vote4 = MT_B16;
		end
	end

	always_comb begin
		priority if (image_size < SIZE_MIN || image_size > SIZE_MAX) begin
			kind = MT_UNKNOWN;
		end else if (h.ab0 && image_size == SIZE_16K) begin
			kind = MT_PLAIN16;
		end else if (h.ab0 && image_size <= SIZE_32K) begin
			kind = h.ab4 ? MT_PLANAR48 : MT_PLAIN32;
		end else if (h.ab0 && snap_flags.sigs_seen && h.sig_x) begin
			kind = MT_B16X;
		end else if (h.ab0 && snap_flags.sigs_seen && h.sig_n8) begin
			kind = MT_NEO8;
		end else if (h.ab0 && snap_flags.sigs_seen && h.sig_n16) begin
			kind = MT_NEO16;
		end else if (image_size == SIZE_512K && h.ab0 && snap_flags.text_seen && h.text) begin
			kind = MT_TEXT512;
		end else if (h.ab4 && image_size <= SIZE_48K) begin
			kind = MT_PLANAR48;
		end else if (image_size == SIZE_64K && h.ab4) begin
			kind = MT_PLANAR64;
		end else if (image_size <= SIZE_32K) begin
			kind = MT_UNKNOWN;
		end else if (vote4 != MT_UNKNOWN) begin
			kind = vote4;
		end else if (image_size == SIZE_64K && h.ab0) begin
			kind = MT_PLANAR64;
		end else if (image_size > SIZE_64K && h.ab0 && image_size[13:0] == '0) begin
			kind = b16_wins_raw ? MT_B16 : MT_B8;
		end else begin
			kind = MT_UNKNOWN;
		end
	end

	assign snap_take = snap_valid && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			res_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_take) begin
			res_type_q <= kind;
		end
	end

	assign res_valid = res_valid_q;
	assign res_type = res_type_q;

endmodule

/* rtl/core/rom_mapper_type_classifier_unit.sv */
// An image's last item passes through the input register, then the snapshot register,
// then the result register. Throughput: one item per cycle; a last item waits
// until the previous snapshot is taken. The scan stage updates all scores in one pass.
// Reset: arst_n clears all valids, scores and positions; image_size returns to 16384.
// No memory is used, so there is no clearing pass after reset.
module rom_mapper_type_classifier_unit import rmtc_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	// Image byte stream.
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
	input  logic             s_axis_tlast,   // last_byte
	// Mapper type results.
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [3:0] mapper_type, [7:4] zero
	// Image length register.
	input  logic             image_size_we,
	input  logic [POS_W-1:0] image_size_wdata
);

	// The block is a short pipeline. The input register holds one byte; when it moves
	// on, the scan stage updates the running position, the header and signature
	// flags and the saturating scores. The last byte of an image instead copies the
	// updated state into a snapshot register and clears the running state, so the
	// next image may start in the following cycle. The decision stage turns the
	// snapshot into a mapper code in the result register.

	logic [POS_W-1:0]       image_size_q;
	logic                   s1_valid;
	logic [7:0]             s1_byte;
	logic                   s1_last;
	logic                   s1_go, step;
	logic                   snap_valid, snap_take;
	logic [COUNT_WIDTH-1:0] snap_cnt_a, snap_cnt_s, snap_cnt_b8, snap_cnt_b16;
	logic [COUNT_WIDTH-1:0] snap_raw0, snap_raw1, snap_raw2;
	snap_flags_t            snap_flags;
	mapper_t                res_type;

	// Only the last item of an image needs room downstream; every other item
	// is absorbed by the scan stage at once.
	assign s1_go = !s1_last || !snap_valid || snap_take;
	assign step = s1_valid && s1_go;
	assign s_axis_tready = !s1_valid || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= SIZE_RESET;
			s1_valid <= 1'b0;
		end else begin
			if (image_size_we) begin
				image_size_q <= image_size_wdata;
			end
			if (s_axis_tready) begin
				s1_valid <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			s1_byte <= s_axis_tdata;
			s1_last <= s_axis_tlast;
		end
	end

	rmtc_scan #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_size   (image_size_q),
		.step         (step),
		.in_byte      (s1_byte),
		.in_last      (s1_last),
		.snap_take    (snap_take),
		.snap_valid   (snap_valid),
		.snap_cnt_a   (snap_cnt_a),
		.snap_cnt_s   (snap_cnt_s),
		.snap_cnt_b8  (snap_cnt_b8),
		.snap_cnt_b16 (snap_cnt_b16),
		.snap_raw0    (snap_raw0),
		.snap_raw1    (snap_raw1),
		.snap_raw2    (snap_raw2),
		.snap_flags   (snap_flags)
	);

	rmtc_decide #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_size   (image_size_q),
		.snap_valid   (snap_valid),
		.snap_cnt_a   (snap_cnt_a),
		.snap_cnt_s   (snap_cnt_s),
		.snap_cnt_b8  (snap_cnt_b8),
		.snap_cnt_b16 (snap_cnt_b16),
		.snap_raw0    (snap_raw0),
		.snap_raw1    (snap_raw1),
		.snap_raw2    (snap_raw2),
		.snap_flags   (snap_flags),
		.snap_take    (snap_take),
		.res_ready    (m_axis_tready),
		.res_valid    (m_axis_tvalid),
		.res_type     (res_type)
	);

	assign m_axis_tdata = {4'b0000, res_type};

endmodule
